// ===== rtl/core/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Operation codes, status codes and the record type of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	localparam int unsigned POS_W   = 5;
	localparam int unsigned COUNT_W = 6;

	typedef struct packed {
		logic signed [31:0] key;
		logic        [31:0] payload;
	} record_t;

endpackage

// ===== rtl/core/sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table
// Record table kept in ascending signed-key order in one synchronous memory;
// stable insert by shifting from the top, lookup by linear scan from entry 0.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-----------------------------------
//  input   | in        | in_valid / in_ready | func, key, payload
//  output  | out       | out_valid/out_ready | status, found_payload, position,
//          |           |                     | entry_count
//
//  One word is worked on at a time. An insert into a table that is neither
//  empty nor full and a lookup in a non-empty table walk the record memory
//  through its single read port: one entry is read, compared and (for insert)
//  written one place up per cycle. Any other word goes straight to its result.
//  Reset clears the record count, the state and out_valid only; the memory
//  needs no clearing pass as entries at or above the count are never looked at.
//  A finished result waits in the output register while the next word is
//  taken; a new result is held back only if the previous one is still unread.
//
module sorted_record_table
	import srt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic signed [31:0]  key,
	input  logic [31:0]         payload,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [31:0]         found_payload,
	output logic [POS_W-1:0]    position,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_LKP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// record memory, one read and one write port, read data registered
	record_t            table_mem [TABLE_DEPTH];
	record_t            rd_rec_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	record_t            mem_wd;

	logic [1:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ins_pos_q;   // slot the new record would take
	logic [AW-1:0]      scan_q;      // address whose data sits in rd_rec_q
	logic signed [31:0] key_q;
	logic [31:0]        pay_q;

	logic [1:0]         res_status_q;
	logic [31:0]        res_payload_q;
	logic [CW-1:0]      res_pos_q;

	logic               in_acc;
	logic               out_free;
	logic [CW+POS_W-1:0]   pos_ext;
	logic [CW+COUNT_W-1:0] cnt_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign pos_ext  = {{POS_W{1'b0}}, res_pos_q};
	assign cnt_ext  = {{COUNT_W{1'b0}}, count_q};

	// read address: the top record ahead of an insert, the next lower record during one, else the next scan entry
	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = (func == FUNC_INSERT) ? AW'(count_q - CW'(1)) : '0;
			ST_INS:  rd_addr = AW'(ins_pos_q - CW'(2));
			ST_LKP:  rd_addr = scan_q + AW'(1);
			default: rd_addr = '0;
		endcase
	end

	// write port: shift a greater record up, or drop the new one in its slot
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '{key: key_q, payload: pay_q};
		if (in_acc && func == FUNC_INSERT && count_q == '0) begin
			mem_we = 1'b1;
			mem_wd = '{key: key, payload: payload};
		end else if (state_q == ST_INS) begin
			mem_we = 1'b1;
			mem_wa = AW'(ins_pos_q);
			if (ins_pos_q != '0 && rd_rec_q.key > key_q) begin
				mem_wd = rd_rec_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= mem_wd;
		end
		rd_rec_q <= table_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						key_q     <= key;
						pay_q     <= payload;
						ins_pos_q <= count_q;
						scan_q    <= '0;
						res_status_q  <= STATUS_OK;
						res_payload_q <= '0;
						res_pos_q     <= '0;
						state_q       <= ST_FIN;
						case (func)
							FUNC_INSERT: begin
								if (count_q == CW'(TABLE_DEPTH)) begin
									res_status_q <= STATUS_FULL;
								end else if (count_q == '0) begin
									count_q <= CW'(1);
								end else begin
									state_q <= ST_INS;
								end
							end
							FUNC_LOOKUP: begin
								if (count_q == '0) begin
									res_status_q <= STATUS_NOT_FOUND;
								end else begin
									state_q <= ST_LKP;
								end
							end
							FUNC_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS: begin
					if (ins_pos_q == '0 || !(rd_rec_q.key > key_q)) begin
						// slot found: the new record lands here
						count_q   <= count_q + CW'(1);
						res_pos_q <= ins_pos_q;
						state_q   <= ST_FIN;
					end else begin
						ins_pos_q <= ins_pos_q - CW'(1);
					end
				end
				ST_LKP: begin
					if (rd_rec_q.key == key_q) begin
						res_payload_q <= rd_rec_q.payload;
						res_pos_q     <= CW'(scan_q);
						state_q       <= ST_FIN;
					end else if (CW'(scan_q) == count_q - CW'(1)) begin
						res_status_q <= STATUS_NOT_FOUND;
						state_q      <= ST_FIN;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load when the slot is free, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			status        <= res_status_q;
			found_payload <= res_payload_q;
			position      <= pos_ext[POS_W-1:0];
			entry_count   <= cnt_ext[COUNT_W-1:0];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("record count above table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LKP |-> CW'(scan_q) < count_q)
		else $error("lookup scan beyond stored records");

	a_ins_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> ins_pos_q < CW'(TABLE_DEPTH) && ins_pos_q <= count_q)
		else $error("insert slot out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish state");

endmodule

// ===== test/tb_sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_record_table
// Drives insert, lookup, clear and spare-code words into the sorted record
// table under random input gaps and output stalls. Every accepted word is run
// through a behavioural copy of the table. Each returned word is compared
// field by field with the oldest expectation still pending.
// ----------------------------------------------------------------------------
module tb_sorted_record_table
	import srt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned TAIL_CYCLES = 100;
	localparam logic [1:0]  FUNC_SPARE  = 2'd3;

	// one word on the input channel
	typedef struct {
		logic [1:0]         func;
		logic signed [31:0] key;
		logic [31:0]        payload;
	} table_word_t;

	// one word on the output channel
	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        found_payload;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] entry_count;
	} table_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         func      = FUNC_INSERT;
	logic signed [31:0] key       = '0;
	logic [31:0]        payload   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [31:0]        found_payload;
	logic [POS_W-1:0]   position;
	logic [COUNT_W-1:0] entry_count;

	// words still to be offered, and results still owed by the block
	table_word_t   pending_words[$];
	table_result_t owed_results[$];

	// behavioural copy of the table
	logic signed [31:0] shadow_key [TABLE_DEPTH];
	logic [31:0]        shadow_pay [TABLE_DEPTH];
	int                 shadow_count = 0;

	// keys inserted since the last clear, used to aim lookups at real entries
	logic signed [31:0] inserted_keys[$];

	int in_wait   = 0;
	int out_wait  = 0;
	bit in_calm   = 1'b0;
	bit out_calm  = 1'b0;
	bit mismatch  = 1'b0;

	sorted_record_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key          (key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_payload(found_payload),
		.position     (position),
		.entry_count  (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one word to the shadow table and return the result it must give.
	// Inserts go after every stored key that is not greater, so equal keys
	// keep their arrival order; lookups report the lowest matching index.
	function automatic table_result_t apply_word(input table_word_t w);
		table_result_t r;
		int            p;
		bit            hit;
		r = '0;
		p = 0;
		hit = 1'b0;
		case (w.func)
			FUNC_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					// full: drop the record, leave the table alone
					r.status = STATUS_FULL;
				end else begin
					p = shadow_count;
					while (p > 0 && shadow_key[p-1] > w.key) begin
						shadow_key[p] = shadow_key[p-1];
						shadow_pay[p] = shadow_pay[p-1];
						p--;
					end
					shadow_key[p] = w.key;
					shadow_pay[p] = w.payload;
					shadow_count++;
					r.status   = STATUS_OK;
					r.position = p[POS_W-1:0];
				end
			end
			FUNC_LOOKUP: begin
				while (!hit && p < shadow_count) begin
					if (shadow_key[p] == w.key)
						hit = 1'b1;
					else
						p++;
				end
				if (hit) begin
					r.status        = STATUS_OK;
					r.found_payload = shadow_pay[p];
					r.position      = p[POS_W-1:0];
				end else begin
					// miss, including any lookup of an empty table
					r.status = STATUS_NOT_FOUND;
				end
			end
			FUNC_CLEAR: begin
				shadow_count = 0;
				r.status     = STATUS_OK;
			end
			default: begin
				// spare code: no operation, count unchanged
				r.status = STATUS_OK;
			end
		endcase
		r.entry_count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 14));
	endfunction

	// Bias keys towards a narrow band (duplicates, hits) and the extremes.
	function automatic logic signed [31:0] pick_key();
		int v;
		case ($urandom_range(0, 3))
			0: begin
				v = $urandom_range(0, 8);
				return v - 4;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return 32'shffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(input logic [1:0] f, input logic signed [31:0] k,
			input logic [31:0] p);
		table_word_t w;
		w.func    = f;
		w.key     = k;
		w.payload = p;
		pending_words.push_back(w);
		if (f == FUNC_INSERT)
			inserted_keys.push_back(k);
		else if (f == FUNC_CLEAR)
			inserted_keys.delete();
	endtask

	task automatic queue_lookup();
		if (inserted_keys.size() > 0 && $urandom_range(0, 9) < 7)
			queue_word(FUNC_LOOKUP,
				inserted_keys[$urandom_range(0, inserted_keys.size() - 1)],
				pick_payload());
		else
			queue_word(FUNC_LOOKUP, pick_key(), pick_payload());
	endtask

	// Input driver: hold each word until it is taken, predict its result at the
	// accepting edge, then either present the next word at once or idle.
	always @(posedge clk) begin
		table_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_ready) begin
			nxt.func    = func;
			nxt.key     = key;
			nxt.payload = payload;
			owed_results.push_back(apply_word(nxt));
			if ($urandom_range(0, 39) == 0)
				in_calm = !in_calm;
			in_wait = draw_gap(in_calm);
			if (in_wait == 0 && pending_words.size() > 0) begin
				// back-to-back: keep valid high, just swap the word
				nxt = pending_words.pop_front();
				func    <= nxt.func;
				key     <= nxt.key;
				payload <= nxt.payload;
			end else begin
				in_valid <= 1'b0;
			end
		end else if (!in_valid) begin
			if (in_wait > 0) begin
				in_wait--;
			end else if (pending_words.size() > 0) begin
				nxt = pending_words.pop_front();
				func     <= nxt.func;
				key      <= nxt.key;
				payload  <= nxt.payload;
				in_valid <= 1'b1;
			end
		end
	end

	// Output monitor: stall ready at random, check every word taken against
	// the oldest owed result.
	always @(posedge clk) begin
		table_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result word with nothing owed: status %0d payload %h pos %0d count %0d",
					$time, status, found_payload, position, entry_count);
				mismatch = 1'b1;
			end else begin
				want = owed_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, status);
					mismatch = 1'b1;
				end
				if (found_payload !== want.found_payload) begin
					$display("%0t: found_payload expected %h got %h",
						$time, want.found_payload, found_payload);
					mismatch = 1'b1;
				end
				if (position !== want.position) begin
					$display("%0t: position expected %0d got %0d",
						$time, want.position, position);
					mismatch = 1'b1;
				end
				if (entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d got %0d",
						$time, want.entry_count, entry_count);
					mismatch = 1'b1;
				end
			end
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
			out_wait = draw_gap(out_calm);
			if (out_wait != 0)
				out_ready <= 1'b0;
		end else if (!out_ready) begin
			if (out_wait > 0)
				out_wait--;
			else
				out_ready <= 1'b1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int ins_pct;
		int ops;
		int r;

		// directed opening: empty table, extremes of key and payload,
		// equal keys, hits at both ends, a miss, the spare code, clear
		queue_word(FUNC_LOOKUP, 32'sd0, 32'h0000_0000);
		queue_word(FUNC_SPARE, 32'shffff_ffff, 32'hffff_ffff);
		queue_word(FUNC_INSERT, 32'sd0, 32'h0000_0000);
		queue_word(FUNC_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
		queue_word(FUNC_INSERT, 32'sh8000_0000, 32'h1234_5678);
		queue_word(FUNC_INSERT, 32'shffff_ffff, 32'ha5a5_a5a5);
		queue_word(FUNC_INSERT, 32'sd0, 32'h5a5a_5a5a);
		queue_word(FUNC_INSERT, 32'sd1, 32'hdead_beef);
		queue_word(FUNC_INSERT, 32'sh7fff_ffff, 32'h0f0f_0f0f);
		queue_word(FUNC_LOOKUP, 32'sd0, 32'hffff_ffff);
		queue_word(FUNC_LOOKUP, 32'sh8000_0000, 32'h0000_0000);
		queue_word(FUNC_LOOKUP, 32'sh7fff_ffff, 32'h0000_0000);
		queue_word(FUNC_LOOKUP, 32'shffff_ffff, 32'h0000_0000);
		queue_word(FUNC_LOOKUP, 32'sd2, 32'h0000_0000);
		queue_word(FUNC_SPARE, 32'sd7, 32'h1357_9bdf);
		queue_word(FUNC_CLEAR, 32'sh8000_0000, 32'hffff_ffff);
		queue_word(FUNC_LOOKUP, 32'sd0, 32'h0000_0000);
		queue_word(FUNC_INSERT, 32'sd5, 32'h0000_0001);
		queue_word(FUNC_INSERT, 32'sd5, 32'h0000_0002);
		queue_word(FUNC_LOOKUP, 32'sd5, 32'h0000_0000);
		queue_word(FUNC_CLEAR, 32'sd0, 32'h0000_0000);

		// random episodes: mostly insert/lookup runs with a per-episode mix,
		// heavy insert runs overflow the table; clears and spare codes rare
		while (pending_words.size() < 1750) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 30;
				1: ins_pct = 60;
				default: ins_pct = 90;
			endcase
			ops = $urandom_range(5, 60);
			repeat (ops) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					queue_word(FUNC_SPARE, $urandom, $urandom);
				else if (r < 3)
					queue_word(FUNC_CLEAR, $urandom, $urandom);
				else if (r < 3 + ins_pct * 97 / 100)
					queue_word(FUNC_INSERT, pick_key(), pick_payload());
				else
					queue_lookup();
			end
			if ($urandom_range(0, 9) < 7)
				queue_word(FUNC_CLEAR, pick_key(), pick_payload());
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// hold until every word is taken, then until every result is back
		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (!mismatch)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/srt_pkg.sv
rtl/core/sorted_record_table.sv
test/tb_sorted_record_table.sv
